/* rtl/rpcs_pkg.sv */
// Shared types, constants and helpers of the RGB pattern crossfade sequencer.
package rpcs_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int OUT_BITS    = 10;
    localparam int POS_W       = $clog2(MAX_ENTRIES);
    localparam int ADDR_W      = POS_W + 1;
    localparam int LEN_W       = 5;
    localparam int CH_W        = 16;
    localparam int RES_W       = 5;
    localparam int TIME_W      = 24;
    localparam int DUTY_W      = 11;
    localparam int BRIGHT_W    = 7;

    localparam logic [LEN_W-1:0]    MAIN_LEN_RESET = LEN_W'(3);
    localparam logic [LEN_W-1:0]    INT_LEN_RESET  = LEN_W'(1);
    localparam logic [31:0]         FST_RESET      = 32'd1000;
    localparam logic [TIME_W-1:0]   DFLT_PAUSE     = TIME_W'(1000);
    localparam logic [TIME_W-1:0]   DFLT_FADE      = TIME_W'(2000);
    localparam logic [CH_W-1:0]     DFLT_LEVEL     = CH_W'(256);
    localparam logic [RES_W-1:0]    DFLT_RES       = RES_W'(10);
    localparam logic [BRIGHT_W-1:0] BRIGHT_MAX     = BRIGHT_W'(100);
    localparam int                  DFLT_COUNT     = 3;

    // x/100 as (x*RECIP)>>RECIP_SHIFT, low by at most one
    localparam logic [12:0] RECIP       = 13'd5242;
    localparam int          RECIP_SHIFT = 19;

    localparam logic [2:0] MODE_TICK   = 3'd0;
    localparam logic [2:0] MODE_WRITE  = 3'd1;
    localparam logic [2:0] MODE_MAIN   = 3'd2;
    localparam logic [2:0] MODE_STATIC = 3'd3;
    localparam logic [2:0] MODE_INTR   = 3'd4;
    localparam logic [2:0] MODE_ON     = 3'd5;
    localparam logic [2:0] MODE_OFF    = 3'd6;
    localparam logic [2:0] MODE_RESEND = 3'd7;

    typedef struct packed {
        logic [CH_W-1:0]   red;
        logic [CH_W-1:0]   green;
        logic [CH_W-1:0]   blue;
        logic [RES_W-1:0]  res;
        logic [TIME_W-1:0] pause;
        logic [TIME_W-1:0] fade;
    } entry_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        entry_t            data;
    } store_wr_t;

    typedef struct packed {
        logic [CH_W-1:0]   cur;
        logic [CH_W-1:0]   nxt;
        logic [TIME_W-1:0] el;
        logic [TIME_W-1:0] fade;
    } lerp_req_t;

    function automatic entry_t default_entry(input logic [1:0] idx);
        entry_t e;
        e.red   = (idx == 2'd0) ? DFLT_LEVEL : '0;
        e.green = (idx == 2'd1) ? DFLT_LEVEL : '0;
        e.blue  = (idx == 2'd2) ? DFLT_LEVEL : '0;
        e.res   = DFLT_RES;
        e.pause = DFLT_PAUSE;
        e.fade  = DFLT_FADE;
        return e;
    endfunction

endpackage

/* rtl/rpcs_store.sv */
// Pattern table memory: main and interrupt entries, one write and one registered read port.
module rpcs_store (
    input  logic                         clk,
    input  logic                         rst_n,
    input  rpcs_pkg::store_wr_t          wr,
    input  logic [rpcs_pkg::ADDR_W-1:0]  raddr,
    output rpcs_pkg::entry_t             rdata
);
    import rpcs_pkg::*;

    entry_t                  mem [0:2*MAX_ENTRIES-1];
    entry_t                  rd_mem_reg;
    logic [DFLT_COUNT-1:0]   written_reg;
    logic                    dflt_sel_reg;
    logic [1:0]              dflt_idx_reg;
    logic [3:0]              written_ext;
    logic                    dflt_hit;

    assign written_ext = {1'b1, written_reg};
    assign dflt_hit    = (raddr < ADDR_W'(DFLT_COUNT)) && !written_ext[raddr[1:0]];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        rd_mem_reg   <= mem[raddr];
        dflt_idx_reg <= raddr[1:0];
    end

    // the first main entries read their power-up values until written
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg  <= '0;
            dflt_sel_reg <= 1'b0;
        end
        else
        begin
            dflt_sel_reg <= dflt_hit;
            if (wr.en && (wr.addr < ADDR_W'(DFLT_COUNT)))
            begin
                written_reg[wr.addr[1:0]] <= 1'b1;
            end
        end
    end

    assign rdata = dflt_sel_reg ? default_entry(dflt_idx_reg) : rd_mem_reg;

endmodule

/* rtl/rpcs_lerp.sv */
// Bit-serial crossfade unit: cur + trunc(el*(nxt-cur)/fade), one bit per cycle.
module rpcs_lerp (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  rpcs_pkg::lerp_req_t        req,
    output logic                       done,
    output logic [rpcs_pkg::CH_W-1:0]  result
);
    import rpcs_pkg::*;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_MUL  = 2'd1;
    localparam logic [1:0] PH_DIV  = 2'd2;
    localparam logic [1:0] PH_FIN  = 2'd3;
    localparam int         PROD_W  = TIME_W + CH_W;

    logic [1:0]        phase_reg, phase_next;
    logic [3:0]        cnt_reg, cnt_next;
    logic [CH_W-1:0]   cur_reg, mag_reg, q_reg;
    logic              neg_reg;
    logic [TIME_W-1:0] el_reg, fade_reg, rem_reg;
    logic [PROD_W-1:0] acc_reg, acc_next;
    logic [CH_W:0]     diff;
    logic [TIME_W:0]   trial;
    logic              qbit;
    logic [CH_W-1:0]   lo;

    assign diff     = {1'b0, req.nxt} - {1'b0, req.cur};
    assign acc_next = {acc_reg[PROD_W-2:0], 1'b0}
                      + (mag_reg[cnt_reg] ? PROD_W'(el_reg) : '0);
    assign lo       = acc_reg[CH_W-1:0];
    assign trial    = {rem_reg, lo[cnt_reg]};
    assign qbit     = (trial >= {1'b0, fade_reg});

    always_comb
    begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        unique case (phase_reg)
            PH_IDLE:
            begin
                if (start)
                begin
                    phase_next = PH_MUL;
                    cnt_next   = '1;
                end
            end
            PH_MUL:
            begin
                cnt_next = cnt_reg - 4'd1;
                if (cnt_reg == 4'd0)
                begin
                    phase_next = PH_DIV;
                    cnt_next   = '1;
                end
            end
            PH_DIV:
            begin
                cnt_next = cnt_reg - 4'd1;
                if (cnt_reg == 4'd0)
                begin
                    phase_next = PH_FIN;
                end
            end
            PH_FIN:  phase_next = PH_IDLE;
            default: phase_next = PH_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (phase_reg)
            PH_IDLE:
            begin
                if (start)
                begin
                    cur_reg  <= req.cur;
                    neg_reg  <= diff[CH_W];
                    mag_reg  <= diff[CH_W] ? CH_W'(-diff) : diff[CH_W-1:0];
                    el_reg   <= req.el;
                    fade_reg <= req.fade;
                    acc_reg  <= '0;
                    q_reg    <= '0;
                end
            end
            PH_MUL:
            begin
                acc_reg <= acc_next;
                // el < fade keeps the quotient within 16 bits
                if (cnt_reg == 4'd0)
                begin
                    rem_reg <= acc_next[PROD_W-1:CH_W];
                end
            end
            PH_DIV:
            begin
                rem_reg <= qbit ? TIME_W'(trial - {1'b0, fade_reg}) : trial[TIME_W-1:0];
                q_reg   <= {q_reg[CH_W-2:0], qbit};
            end
            default:
            begin
            end
        endcase
    end

    assign done   = (phase_reg == PH_FIN);
    assign result = neg_reg ? (cur_reg - q_reg) : (cur_reg + q_reg);

endmodule

/* rtl/rgb_pattern_crossfade_sequencer_core.sv */
// Top level of the RGB pattern crossfade sequencer.
// Commands arrive as stream transactions: tuser carries the mode and table select,
// tdata the entry fields. A tick transaction advances the pattern by one millisecond
// and, while power is on and a static colour has not yet been sent, yields one
// transaction of three duty levels (0..1024) and the interrupt flag; power off yields
// one transaction of zero duty levels. Other modes yield nothing. One command is
// handled at a time. Start main (outside an interrupt) and start interrupt read the
// table for the pause. During a fade a tick runs the bit-serial multiply and divide
// of the crossfade unit for the three channels in turn; every output ends with
// brightness scaling of each channel. A finished result waits in the output register
// while the next command is taken. Brightness is to be written through cfg_wr_en /
// cfg_wr_data only while the block is idle; the block itself does not enforce this.
// Values above 100 act as 100.
module rgb_pattern_crossfade_sequencer_core (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // entry_index[3:0] red[19:4] green[35:20] blue[51:36] colour_resolution[56:52]
    // pause_ms[80:57] fade_ms[104:81] pattern_length[109:105], zero fill above
    input  logic [111:0]  s_axis_tdata,
    // mode[2:0] table_select[3]
    input  logic [3:0]    s_axis_tuser,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // red_duty[10:0] green_duty[21:11] blue_duty[32:22], zero fill above
    output logic [39:0]   m_axis_tdata,
    // interrupt_active[0]
    output logic [0:0]    m_axis_tuser,
    input  logic          cfg_wr_en,
    input  logic [6:0]    cfg_wr_data
);
    import rpcs_pkg::*;

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_TF_REQ = 5'd1;
    localparam logic [4:0] S_TF_CHK = 5'd2;
    localparam logic [4:0] S_P_REQ  = 5'd3;
    localparam logic [4:0] S_P_ADD  = 5'd4;
    localparam logic [4:0] S_EMIT   = 5'd5;
    localparam logic [4:0] S_C_REQ  = 5'd6;
    localparam logic [4:0] S_C_CHK  = 5'd7;
    localparam logic [4:0] S_N_REQ  = 5'd8;
    localparam logic [4:0] S_N_CHK  = 5'd9;
    localparam logic [4:0] S_LG     = 5'd10;
    localparam logic [4:0] S_LW     = 5'd11;
    localparam logic [4:0] S_SC1    = 5'd12;
    localparam logic [4:0] S_SC2    = 5'd13;
    localparam logic [4:0] S_SC3    = 5'd14;
    localparam logic [4:0] S_OUT    = 5'd15;

    localparam int SHIFT_W = CH_W + OUT_BITS;

    // input fields
    logic [2:0]        in_mode;
    logic              in_tsel;
    logic [POS_W-1:0]  in_idx;
    logic [LEN_W-1:0]  in_len, len_clamped;
    entry_t            in_entry;

    assign in_mode        = s_axis_tuser[2:0];
    assign in_tsel        = s_axis_tuser[3];
    assign in_idx         = s_axis_tdata[3:0];
    assign in_entry.red   = s_axis_tdata[19:4];
    assign in_entry.green = s_axis_tdata[35:20];
    assign in_entry.blue  = s_axis_tdata[51:36];
    assign in_entry.res   = s_axis_tdata[56:52];
    assign in_entry.pause = s_axis_tdata[80:57];
    assign in_entry.fade  = s_axis_tdata[104:81];
    assign in_len         = s_axis_tdata[109:105];
    assign len_clamped    = (in_len == '0) ? LEN_W'(1)
                          : (in_len > LEN_W'(MAX_ENTRIES)) ? LEN_W'(MAX_ENTRIES) : in_len;

    // sequencer state
    logic [4:0]          state_reg, state_next;
    logic [31:0]         time_now_reg, time_now_next;
    logic [31:0]         fst_reg, fst_next;
    logic [POS_W-1:0]    main_pos_reg, main_pos_next, int_pos_reg, int_pos_next;
    logic [LEN_W-1:0]    main_len_reg, main_len_next, int_len_reg, int_len_next;
    logic                main_static_reg, main_static_next;
    logic                in_int_reg, in_int_next;
    logic                power_reg, power_next;
    logic                sent_reg, sent_next;
    logic [BRIGHT_W-1:0] bright_reg;
    logic                cont_reg, cont_next;
    logic                static_path_reg, static_path_next;
    logic [ADDR_W-1:0]   raddr_reg, raddr_next;
    logic [1:0]          ch_reg, ch_next;
    logic                out_valid_reg, out_valid_next;
    logic                out_load;

    // datapath registers
    logic [31:0]         pbase_reg;
    logic [CH_W-1:0]     val_reg [0:2];
    logic [CH_W-1:0]     nval_reg [0:2];
    logic [RES_W-1:0]    res_reg;
    logic [TIME_W-1:0]   fade_reg, el_reg;
    logic [16:0]         p_reg;
    logic [DUTY_W-1:0]   q_reg;
    logic [DUTY_W-1:0]   duty_reg [0:2];
    logic [DUTY_W-1:0]   out_duty_reg [0:2];
    logic                out_int_reg;

    // store and crossfade unit
    store_wr_t           wr;
    entry_t              rdata;
    lerp_req_t           lreq;
    logic                lstart, ldone;
    logic [CH_W-1:0]     lresult;

    // shared combinational terms
    logic                accept;
    logic [POS_W-1:0]    pos, npos;
    logic [LEN_W-1:0]    plen;
    logic                last;
    logic [32:0]         change;
    logic [31:0]         el_full;
    logic [RES_W-1:0]    res_c;
    logic [SHIFT_W-1:0]  shifted;
    logic [OUT_BITS:0]   sat;
    logic [BRIGHT_W-1:0] bright_c;
    logic [17:0]         prod_b;
    logic [29:0]         prod_r;
    logic [17:0]         q100, rem100;

    assign accept   = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE);

    assign pos    = in_int_reg ? int_pos_reg : main_pos_reg;
    assign plen   = in_int_reg ? int_len_reg : main_len_reg;
    assign last   = ({1'b0, pos} + LEN_W'(1)) >= plen;
    assign npos   = last ? '0 : pos + POS_W'(1);
    assign change = {1'b0, fst_reg} + {9'b0, rdata.fade};
    assign el_full = time_now_reg - fst_reg;

    // scale: resolution to OUT_BITS, saturate, then brightness percent
    assign res_c    = (res_reg == '0) ? RES_W'(1)
                    : (res_reg > RES_W'(16)) ? RES_W'(16) : res_reg;
    assign shifted  = {val_reg[ch_reg], OUT_BITS'(0)} >> res_c;
    assign sat      = (shifted > SHIFT_W'(1 << OUT_BITS)) ? (OUT_BITS+1)'(1 << OUT_BITS)
                    : shifted[OUT_BITS:0];
    assign bright_c = (bright_reg > BRIGHT_MAX) ? BRIGHT_MAX : bright_reg;
    assign prod_b   = 18'(sat) * 18'(bright_c);
    assign prod_r   = 30'(p_reg) * 30'(RECIP);
    assign q100     = 18'(q_reg) * 18'(BRIGHT_MAX);
    assign rem100   = 18'(p_reg) - q100;

    assign lreq.cur  = val_reg[ch_reg];
    assign lreq.nxt  = nval_reg[ch_reg];
    assign lreq.el   = el_reg;
    assign lreq.fade = fade_reg;
    assign lstart    = (state_reg == S_LG);

    always_comb
    begin
        wr.en   = 1'b0;
        wr.addr = {in_tsel, in_idx};
        wr.data = in_entry;
        if (accept && (in_mode == MODE_WRITE))
        begin
            wr.en = 1'b1;
        end
        else if (accept && (in_mode == MODE_STATIC))
        begin
            wr.en         = 1'b1;
            wr.addr       = '0;
            wr.data.pause = '0;
            wr.data.fade  = '0;
        end
    end

    rpcs_store u_store (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (wr),
        .raddr (raddr_reg),
        .rdata (rdata)
    );

    rpcs_lerp u_lerp (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (lstart),
        .req    (lreq),
        .done   (ldone),
        .result (lresult)
    );

    // control sequencer
    always_comb
    begin
        state_next       = state_reg;
        time_now_next    = time_now_reg;
        fst_next         = fst_reg;
        main_pos_next    = main_pos_reg;
        int_pos_next     = int_pos_reg;
        main_len_next    = main_len_reg;
        int_len_next     = int_len_reg;
        main_static_next = main_static_reg;
        in_int_next      = in_int_reg;
        power_next       = power_reg;
        sent_next        = sent_reg;
        cont_next        = cont_reg;
        static_path_next = static_path_reg;
        raddr_next       = raddr_reg;
        ch_next          = ch_reg;
        out_load         = 1'b0;
        if (cfg_wr_en)
        begin
            sent_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (in_mode)
                        MODE_TICK:
                        begin
                            time_now_next = time_now_reg + 32'd1;
                            if (in_int_reg || !main_static_reg)
                            begin
                                raddr_next = {in_int_reg, pos};
                                state_next = S_TF_REQ;
                            end
                            else
                            begin
                                state_next = S_EMIT;
                            end
                        end
                        MODE_WRITE:
                        begin
                        end
                        MODE_MAIN:
                        begin
                            main_pos_next    = '0;
                            main_len_next    = len_clamped;
                            main_static_next = 1'b0;
                            if (!in_int_reg)
                            begin
                                sent_next  = 1'b0;
                                raddr_next = '0;
                                cont_next  = 1'b0;
                                state_next = S_P_REQ;
                            end
                        end
                        MODE_STATIC:
                        begin
                            main_pos_next    = '0;
                            main_len_next    = LEN_W'(1);
                            main_static_next = 1'b1;
                            if (!in_int_reg)
                            begin
                                fst_next  = '0;
                                sent_next = 1'b0;
                            end
                        end
                        MODE_INTR:
                        begin
                            int_pos_next = '0;
                            int_len_next = len_clamped;
                            in_int_next  = 1'b1;
                            sent_next    = 1'b0;
                            raddr_next   = ADDR_W'(MAX_ENTRIES);
                            cont_next    = 1'b0;
                            state_next   = S_P_REQ;
                        end
                        MODE_ON:
                        begin
                            power_next = 1'b1;
                            fst_next   = time_now_reg;
                        end
                        MODE_OFF:
                        begin
                            power_next = 1'b0;
                            sent_next  = 1'b0;
                            ch_next    = '0;
                            state_next = S_SC1;
                        end
                        MODE_RESEND: sent_next = 1'b0;
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_TF_REQ: state_next = S_TF_CHK;
            S_TF_CHK:
            begin
                state_next = S_EMIT;
                if (change <= {1'b0, time_now_reg})
                begin
                    cont_next  = 1'b1;
                    state_next = S_P_REQ;
                    if (last && in_int_reg)
                    begin
                        // interrupt done: resume the saved entry at its pause
                        in_int_next = 1'b0;
                        sent_next   = 1'b0;
                        raddr_next  = {1'b0, main_pos_reg};
                    end
                    else
                    begin
                        raddr_next = {in_int_reg, npos};
                        if (in_int_reg)
                        begin
                            int_pos_next = npos;
                        end
                        else
                        begin
                            main_pos_next = npos;
                        end
                    end
                end
            end
            S_P_REQ: state_next = S_P_ADD;
            S_P_ADD:
            begin
                fst_next   = pbase_reg + {8'b0, rdata.pause};
                state_next = cont_reg ? S_EMIT : S_IDLE;
            end
            S_EMIT:
            begin
                if (sent_reg || !power_reg)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    static_path_next = !in_int_reg && main_static_reg;
                    raddr_next = (!in_int_reg && main_static_reg) ? '0 : {in_int_reg, pos};
                    state_next = S_C_REQ;
                end
            end
            S_C_REQ: state_next = S_C_CHK;
            S_C_CHK:
            begin
                ch_next = '0;
                if (static_path_reg)
                begin
                    sent_next  = 1'b1;
                    state_next = S_SC1;
                end
                else if (fst_reg > time_now_reg)
                begin
                    state_next = S_SC1;
                end
                else
                begin
                    raddr_next = {in_int_reg, npos};
                    state_next = S_N_REQ;
                end
            end
            S_N_REQ: state_next = S_N_CHK;
            S_N_CHK:
            begin
                ch_next = '0;
                if ((fade_reg == '0) || (el_full >= {8'b0, fade_reg}))
                begin
                    state_next = S_SC1;
                end
                else
                begin
                    state_next = S_LG;
                end
            end
            S_LG: state_next = S_LW;
            S_LW:
            begin
                if (ldone)
                begin
                    if (ch_reg == 2'd2)
                    begin
                        ch_next    = '0;
                        state_next = S_SC1;
                    end
                    else
                    begin
                        ch_next    = ch_reg + 2'd1;
                        state_next = S_LG;
                    end
                end
            end
            S_SC1: state_next = S_SC2;
            S_SC2: state_next = S_SC3;
            S_SC3:
            begin
                if (ch_reg == 2'd2)
                begin
                    ch_next    = '0;
                    state_next = S_OUT;
                end
                else
                begin
                    ch_next    = ch_reg + 2'd1;
                    state_next = S_SC1;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            time_now_reg    <= '0;
            fst_reg         <= FST_RESET;
            main_pos_reg    <= '0;
            int_pos_reg     <= '0;
            main_len_reg    <= MAIN_LEN_RESET;
            int_len_reg     <= INT_LEN_RESET;
            main_static_reg <= 1'b0;
            in_int_reg      <= 1'b0;
            power_reg       <= 1'b0;
            sent_reg        <= 1'b0;
            bright_reg      <= '0;
            cont_reg        <= 1'b0;
            static_path_reg <= 1'b0;
            raddr_reg       <= '0;
            ch_reg          <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            time_now_reg    <= time_now_next;
            fst_reg         <= fst_next;
            main_pos_reg    <= main_pos_next;
            int_pos_reg     <= int_pos_next;
            main_len_reg    <= main_len_next;
            int_len_reg     <= int_len_next;
            main_static_reg <= main_static_next;
            in_int_reg      <= in_int_next;
            power_reg       <= power_next;
            sent_reg        <= sent_next;
            cont_reg        <= cont_next;
            static_path_reg <= static_path_next;
            raddr_reg       <= raddr_next;
            ch_reg          <= ch_next;
            out_valid_reg   <= out_valid_next;
            if (cfg_wr_en)
            begin
                bright_reg <= cfg_wr_data;
            end
        end
    end

    // datapath: colour capture, crossfade results, scaling and output hold
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                pbase_reg <= time_now_reg;
                for (int i = 0; i < 3; i++)
                begin
                    val_reg[i] <= '0;
                end
                res_reg <= RES_W'(1);
            end
            S_TF_CHK:
            begin
                pbase_reg <= (last && in_int_reg) ? time_now_reg : change[31:0];
            end
            S_C_CHK:
            begin
                val_reg[0] <= rdata.red;
                val_reg[1] <= rdata.green;
                val_reg[2] <= rdata.blue;
                res_reg    <= rdata.res;
                fade_reg   <= rdata.fade;
            end
            S_N_CHK:
            begin
                el_reg <= el_full[TIME_W-1:0];
                if ((fade_reg == '0) || (el_full >= {8'b0, fade_reg}))
                begin
                    val_reg[0] <= rdata.red;
                    val_reg[1] <= rdata.green;
                    val_reg[2] <= rdata.blue;
                end
                else
                begin
                    nval_reg[0] <= rdata.red;
                    nval_reg[1] <= rdata.green;
                    nval_reg[2] <= rdata.blue;
                end
            end
            S_LW:
            begin
                if (ldone)
                begin
                    val_reg[ch_reg] <= lresult;
                end
            end
            S_SC1: p_reg <= prod_b[16:0];
            S_SC2: q_reg <= prod_r[RECIP_SHIFT+DUTY_W-1:RECIP_SHIFT];
            S_SC3:
            begin
                duty_reg[ch_reg] <= (rem100 >= 18'(BRIGHT_MAX)) ? q_reg + DUTY_W'(1) : q_reg;
            end
            S_OUT:
            begin
                if (out_load)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        out_duty_reg[i] <= duty_reg[i];
                    end
                    out_int_reg <= in_int_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'b0, out_duty_reg[2], out_duty_reg[1], out_duty_reg[0]};
    assign m_axis_tuser  = out_int_reg;

endmodule
